// ===== design/lav_pkg.sv =====
// lav_pkg: shared widths, constants and rounding helpers for the look-at view matrix pipeline
// used by lav_sqrt, lav_div3 and look_at_view_matrix; no dependencies
`timescale 1ns / 1ps

package lav_pkg;

    localparam int IN_W        = 16;   // q7.8 input component
    localparam int D_W         = 17;   // target - eye
    localparam int SQ_W        = 33;   // square of one difference
    localparam int L2_W        = 34;   // squared length
    localparam int LEN_SHIFT   = 28;   // extra fraction bits before the first root
    localparam int SQ_IN_W     = 62;   // root unit radicand
    localparam int SQ_OUT_W    = 31;   // root unit result
    localparam int SQ_STAGES   = SQ_OUT_W;
    localparam int DN_W        = 47;   // divider numerator
    localparam int DD_W        = 32;   // divider denominator
    localparam int Q_W         = 16;   // divider quotient
    localparam int DIV_STAGES  = Q_W;
    localparam int N_SHIFT     = 29;   // 2 * d * 2^28
    localparam int V_SHIFT     = 15;   // 2 * r * 2^14
    localparam int UP_SHIFT    = 28;
    localparam int PROD_W      = 48;
    localparam int R_PROD_W    = 2 * IN_W;   // product of two 16-bit components
    localparam int R_W         = 32;   // orthogonal part, q.22
    localparam int RMAG_W      = 31;
    localparam int SIDE_W      = 193;  // sideband carried through root and divide units
    localparam int UNIT_W      = 16;
    localparam int SHIFT_W     = 24;
    localparam int ONE_Q14     = 16384;
    localparam int SHIFT_MAX   = 8388607;
    localparam int SHIFT_MIN   = -8388608;
    localparam int S_TDATA_W   = 9 * IN_W;
    localparam int M_TDATA_W   = 9 * UNIT_W + 3 * SHIFT_W;

    // round(x / 2^14), half away from zero
    function automatic logic signed [PROD_W-1:0] rnd14(input logic signed [PROD_W-1:0] x);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] q;
        mag = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
        q   = (mag + PROD_W'(8192)) >> 14;
        return x[PROD_W-1] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [UNIT_W-1:0] clamp_unit(input logic signed [PROD_W-1:0] x);
        if (x > PROD_W'(ONE_Q14)) begin
            return UNIT_W'(ONE_Q14);
        end else if (x < -PROD_W'(ONE_Q14)) begin
            return -UNIT_W'(ONE_Q14);
        end
        return x[UNIT_W-1:0];
    endfunction

    function automatic logic signed [SHIFT_W-1:0] sat_shift(input logic signed [PROD_W-1:0] x);
        if (x > PROD_W'(SHIFT_MAX)) begin
            return SHIFT_W'(SHIFT_MAX);
        end else if (x < PROD_W'(SHIFT_MIN)) begin
            return SHIFT_W'(SHIFT_MIN);
        end
        return x[SHIFT_W-1:0];
    endfunction

endpackage

// ===== design/lav_sqrt.sv =====
// lav_sqrt: pipelined floor square root, one result bit per register stage
// depends on lav_pkg
`timescale 1ns / 1ps

module lav_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [lav_pkg::SQ_IN_W-1:0]   in_x,
    input  logic [lav_pkg::SIDE_W-1:0]    in_side,
    output logic                          out_valid,
    output logic [lav_pkg::SQ_OUT_W-1:0]  out_root,
    output logic [lav_pkg::SIDE_W-1:0]    out_side
);

    logic [lav_pkg::SQ_STAGES-1:0] valid_reg;
    logic [lav_pkg::SQ_IN_W-1:0]   rem_reg   [lav_pkg::SQ_STAGES];
    logic [lav_pkg::SQ_IN_W-1:0]   rem_next  [lav_pkg::SQ_STAGES];
    logic [lav_pkg::SQ_OUT_W-1:0]  root_reg  [lav_pkg::SQ_STAGES];
    logic [lav_pkg::SQ_OUT_W-1:0]  root_next [lav_pkg::SQ_STAGES];
    logic [lav_pkg::SIDE_W-1:0]    side_reg  [lav_pkg::SQ_STAGES];

    // stage k decides root bit SQ_STAGES-1-k; rem holds x - root^2
    always_comb begin
        logic [lav_pkg::SQ_IN_W-1:0]  rem_in;
        logic [lav_pkg::SQ_OUT_W-1:0] root_in;
        logic [lav_pkg::SQ_IN_W+1:0]  trial;
        for (int k = 0; k < lav_pkg::SQ_STAGES; k++) begin
            rem_in  = (k == 0) ? in_x : rem_reg[(k == 0) ? 0 : k-1];
            root_in = (k == 0) ? '0 : root_reg[(k == 0) ? 0 : k-1];
            trial   = ((lav_pkg::SQ_IN_W+2)'(root_in) << (lav_pkg::SQ_STAGES - k))
                    | ((lav_pkg::SQ_IN_W+2)'(1) << (2 * (lav_pkg::SQ_STAGES - 1 - k)));
            if ({2'b00, rem_in} >= trial) begin
                rem_next[k]  = rem_in - trial[lav_pkg::SQ_IN_W-1:0];
                root_next[k] = root_in | (lav_pkg::SQ_OUT_W'(1) << (lav_pkg::SQ_STAGES - 1 - k));
            end else begin
                rem_next[k]  = rem_in;
                root_next[k] = root_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[lav_pkg::SQ_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < lav_pkg::SQ_STAGES; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign out_valid = valid_reg[lav_pkg::SQ_STAGES-1];
    assign out_root  = root_reg[lav_pkg::SQ_STAGES-1];
    assign out_side  = side_reg[lav_pkg::SQ_STAGES-1];

endmodule

// ===== design/lav_div3.sv =====
// lav_div3: three-lane pipelined restoring divider sharing one denominator
// depends on lav_pkg
`timescale 1ns / 1ps

module lav_div3 (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [2:0][lav_pkg::DN_W-1:0]     in_num,
    input  logic [2:0]                        in_neg,
    input  logic [lav_pkg::DD_W-1:0]          in_den,
    input  logic [lav_pkg::SIDE_W-1:0]        in_side,
    output logic                              out_valid,
    output logic [2:0][lav_pkg::Q_W-1:0]      out_q,
    output logic [2:0]                        out_neg,
    output logic [lav_pkg::SIDE_W-1:0]        out_side
);

    logic [lav_pkg::DIV_STAGES-1:0]    valid_reg;
    logic [2:0][lav_pkg::DN_W-1:0]     rem_reg  [lav_pkg::DIV_STAGES];
    logic [2:0][lav_pkg::DN_W-1:0]     rem_next [lav_pkg::DIV_STAGES];
    logic [2:0][lav_pkg::Q_W-1:0]      q_reg    [lav_pkg::DIV_STAGES];
    logic [2:0][lav_pkg::Q_W-1:0]      q_next   [lav_pkg::DIV_STAGES];
    logic [2:0]                        neg_reg  [lav_pkg::DIV_STAGES];
    logic [lav_pkg::DD_W-1:0]          den_reg  [lav_pkg::DIV_STAGES];
    logic [lav_pkg::SIDE_W-1:0]        side_reg [lav_pkg::DIV_STAGES];

    // stage k decides quotient bit DIV_STAGES-1-k in every lane
    always_comb begin
        logic [lav_pkg::DN_W-1:0] rem_in;
        logic [lav_pkg::Q_W-1:0]  q_in;
        logic [lav_pkg::DD_W-1:0] den_in;
        logic [lav_pkg::DN_W:0]   trial;
        for (int k = 0; k < lav_pkg::DIV_STAGES; k++) begin
            den_in = (k == 0) ? in_den : den_reg[(k == 0) ? 0 : k-1];
            trial  = (lav_pkg::DN_W+1)'(den_in) << (lav_pkg::DIV_STAGES - 1 - k);
            for (int j = 0; j < 3; j++) begin
                rem_in = (k == 0) ? in_num[j] : rem_reg[(k == 0) ? 0 : k-1][j];
                q_in   = (k == 0) ? '0 : q_reg[(k == 0) ? 0 : k-1][j];
                if ({1'b0, rem_in} >= trial) begin
                    rem_next[k][j] = rem_in - trial[lav_pkg::DN_W-1:0];
                    q_next[k][j]   = q_in | (lav_pkg::Q_W'(1) << (lav_pkg::DIV_STAGES - 1 - k));
                end else begin
                    rem_next[k][j] = rem_in;
                    q_next[k][j]   = q_in;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[lav_pkg::DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < lav_pkg::DIV_STAGES; k++) begin
                rem_reg[k]  <= rem_next[k];
                q_reg[k]    <= q_next[k];
                den_reg[k]  <= (k == 0) ? in_den  : den_reg[(k == 0) ? 0 : k-1];
                neg_reg[k]  <= (k == 0) ? in_neg  : neg_reg[(k == 0) ? 0 : k-1];
                side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign out_valid = valid_reg[lav_pkg::DIV_STAGES-1];
    assign out_q     = q_reg[lav_pkg::DIV_STAGES-1];
    assign out_neg   = neg_reg[lav_pkg::DIV_STAGES-1];
    assign out_side  = side_reg[lav_pkg::DIV_STAGES-1];

endmodule

// ===== design/look_at_view_matrix.sv =====
// look_at_view_matrix: fixed-point look-at view matrix, fully pipelined
// depends on lav_pkg, lav_sqrt and lav_div3
`timescale 1ns / 1ps

// takes one transaction of eye, target and up (q7.8) per clock and returns the view
// rotation rows w, v and -n in q1.14 plus the saturated q15.8 translation column.
// throughput is one transaction per cycle unless stalled; the depth comes mostly from
// the two 31-stage square-root pipelines and the two 16-stage divide pipelines. the
// whole pipeline advances together and freezes when the output register is full and
// m_axis_tready is low, so s_axis_tready follows that condition. when target equals
// eye, or up is parallel to the view direction, every output field is zero.
module look_at_view_matrix (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z (16 bits each)
    input  logic [lav_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // right_x/y/z, upward_x/y/z, back_x/y/z (16 bits each),
    // shift_row0, shift_row1, shift_row2 (24 bits each)
    output logic [lav_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    logic en;   // global advance

    // front: difference, squares, squared length
    logic                              p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic signed [lav_pkg::IN_W-1:0]   eye1_reg [3], up1_reg [3];
    logic signed [lav_pkg::D_W-1:0]    d1_reg [3];
    logic signed [lav_pkg::IN_W-1:0]   eye2_reg [3], up2_reg [3];
    logic signed [lav_pkg::D_W-1:0]    d2_reg [3];
    logic [lav_pkg::SQ_W-1:0]          sq2_reg [3];
    logic signed [lav_pkg::IN_W-1:0]   eye3_reg [3], up3_reg [3];
    logic signed [lav_pkg::D_W-1:0]    d3_reg [3];
    logic [lav_pkg::L2_W-1:0]          l2_reg;
    logic signed [2*lav_pkg::D_W-1:0]  sq_prod [3];
    logic [lav_pkg::L2_W-1:0]          l2_next;

    // first root
    logic [lav_pkg::SQ_IN_W-1:0]  sq1_x;
    logic [lav_pkg::SIDE_W-1:0]   sq1_side, sq1_out_side;
    logic                         sq1_valid;
    logic [lav_pkg::SQ_OUT_W-1:0] lq;

    // numerator set-up for n
    logic                              p4_valid_reg;
    logic [2:0][lav_pkg::DN_W-1:0]     num4_reg;
    logic [2:0]                        neg4_reg;
    logic [lav_pkg::DD_W-1:0]          den4_reg;
    logic [lav_pkg::SIDE_W-1:0]        side4_reg;
    logic [2:0][lav_pkg::Q_W-1:0]      div1_q;
    logic [2:0]                        div1_neg;
    logic [lav_pkg::SIDE_W-1:0]        div1_side;
    logic                              div1_valid;

    // orthogonalization
    logic p5_valid_reg, p6_valid_reg, p7_valid_reg, p8_valid_reg;
    logic p9_valid_reg, p10_valid_reg, p11_valid_reg;
    logic signed [lav_pkg::UNIT_W-1:0] n5_reg [3], n6_reg [3], n7_reg [3], n8_reg [3];
    logic signed [lav_pkg::UNIT_W-1:0] n9_reg [3], n10_reg [3], n11_reg [3];
    logic signed [lav_pkg::IN_W-1:0]   up5_reg [3], up6_reg [3], up7_reg [3], up8_reg [3];
    logic signed [lav_pkg::IN_W-1:0]   eye5_reg [3], eye6_reg [3], eye7_reg [3], eye8_reg [3];
    logic signed [lav_pkg::IN_W-1:0]   eye9_reg [3], eye10_reg [3], eye11_reg [3];
    logic                              zero5_reg, zero6_reg, zero7_reg, zero8_reg;
    logic                              zero9_reg, zero10_reg, zero11_reg;
    logic signed [lav_pkg::R_PROD_W-1:0] pun6_reg [3];
    logic signed [lav_pkg::R_PROD_W:0]   a7_reg;
    logic signed [lav_pkg::PROD_W-1:0] an8_reg [3];
    logic signed [lav_pkg::R_W-1:0]    r9_reg [3];
    logic [lav_pkg::RMAG_W-1:0]        rmag10_reg [3], rmag11_reg [3];
    logic [2:0]                        rneg10_reg, rneg11_reg;
    logic [lav_pkg::SQ_IN_W-1:0]       rsq10_reg [3];
    logic [lav_pkg::SQ_IN_W-1:0]       vs11_reg;
    logic signed [lav_pkg::UNIT_W-1:0] n5_next [3];
    logic [lav_pkg::R_W-1:0]           rm_abs [3];

    // second root and divide
    logic [lav_pkg::SIDE_W-1:0]   sq2_side, sq2_out_side;
    logic                         sq2_valid;
    logic [lav_pkg::SQ_OUT_W-1:0] vq;
    logic                         p12_valid_reg;
    logic [2:0][lav_pkg::DN_W-1:0] num12_reg;
    logic [2:0]                   neg12_reg;
    logic [lav_pkg::DD_W-1:0]     den12_reg;
    logic [lav_pkg::SIDE_W-1:0]   side12_reg;
    logic [2:0][lav_pkg::Q_W-1:0] div2_q;
    logic [2:0]                   div2_neg;
    logic [lav_pkg::SIDE_W-1:0]   div2_side;
    logic                         div2_valid;

    // back end: cross product, translation, output register
    logic p13_valid_reg, p14_valid_reg, p15_valid_reg, p16_valid_reg, m_valid_reg;
    logic signed [lav_pkg::UNIT_W-1:0] v13_reg [3], v14_reg [3], v15_reg [3], v16_reg [3];
    logic signed [lav_pkg::UNIT_W-1:0] n13_reg [3], n14_reg [3], n15_reg [3], n16_reg [3];
    logic signed [lav_pkg::UNIT_W-1:0] w15_reg [3], w16_reg [3];
    logic signed [lav_pkg::IN_W-1:0]   eye13_reg [3], eye14_reg [3], eye15_reg [3];
    logic                              zero13_reg, zero14_reg, zero15_reg, zero16_reg;
    logic signed [lav_pkg::R_PROD_W-1:0] cr14_reg [6];
    logic signed [lav_pkg::R_PROD_W-1:0] pw16_reg [3], pv16_reg [3], pn16_reg [3];
    logic signed [lav_pkg::UNIT_W-1:0] v13_next [3], w15_next [3];
    logic signed [lav_pkg::SHIFT_W-1:0] t_next [3];
    logic [lav_pkg::M_TDATA_W-1:0]     m_data_reg, m_data_next;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // ---------------- combinational stage math ----------------
    always_comb begin
        logic [lav_pkg::Q_W-1:0]          qc;
        logic signed [lav_pkg::PROD_W-1:0] dif;
        logic signed [lav_pkg::PROD_W-1:0] dsum;
        for (int i = 0; i < 3; i++) begin
            sq_prod[i] = d1_reg[i] * d1_reg[i];
        end
        l2_next = lav_pkg::L2_W'(sq2_reg[0]) + lav_pkg::L2_W'(sq2_reg[1])
                + lav_pkg::L2_W'(sq2_reg[2]);

        // unit direction from the first divider
        for (int i = 0; i < 3; i++) begin
            qc = (div1_q[i] > lav_pkg::Q_W'(lav_pkg::ONE_Q14)) ?
                 lav_pkg::Q_W'(lav_pkg::ONE_Q14) : div1_q[i];
            n5_next[i] = div1_neg[i] ? -$signed(qc) : $signed(qc);
        end

        for (int i = 0; i < 3; i++) begin
            rm_abs[i] = r9_reg[i][lav_pkg::R_W-1] ? lav_pkg::R_W'(-r9_reg[i])
                                                   : lav_pkg::R_W'(r9_reg[i]);
        end

        // up direction from the second divider
        for (int i = 0; i < 3; i++) begin
            qc = (div2_q[i] > lav_pkg::Q_W'(lav_pkg::ONE_Q14)) ?
                 lav_pkg::Q_W'(lav_pkg::ONE_Q14) : div2_q[i];
            v13_next[i] = div2_neg[i] ? -$signed(qc) : $signed(qc);
        end

        // w = n x v, products ordered as pairs (plus, minus) per component
        for (int i = 0; i < 3; i++) begin
            dif = lav_pkg::PROD_W'(cr14_reg[2*i]) - lav_pkg::PROD_W'(cr14_reg[2*i+1]);
            w15_next[i] = lav_pkg::clamp_unit(lav_pkg::rnd14(dif));
        end

        // translation: -(w.eye), -(v.eye), n.eye
        dsum = lav_pkg::PROD_W'(pw16_reg[0]) + lav_pkg::PROD_W'(pw16_reg[1])
             + lav_pkg::PROD_W'(pw16_reg[2]);
        t_next[0] = lav_pkg::sat_shift(-lav_pkg::rnd14(dsum));
        dsum = lav_pkg::PROD_W'(pv16_reg[0]) + lav_pkg::PROD_W'(pv16_reg[1])
             + lav_pkg::PROD_W'(pv16_reg[2]);
        t_next[1] = lav_pkg::sat_shift(-lav_pkg::rnd14(dsum));
        dsum = lav_pkg::PROD_W'(pn16_reg[0]) + lav_pkg::PROD_W'(pn16_reg[1])
             + lav_pkg::PROD_W'(pn16_reg[2]);
        t_next[2] = lav_pkg::sat_shift(lav_pkg::rnd14(dsum));

        if (zero16_reg) begin
            m_data_next = '0;
        end else begin
            m_data_next = {t_next[2], t_next[1], t_next[0],
                           -n16_reg[2], -n16_reg[1], -n16_reg[0],
                           v16_reg[2], v16_reg[1], v16_reg[0],
                           w16_reg[2], w16_reg[1], w16_reg[0]};
        end
    end

    // ---------------- root and divide units ----------------
    // sideband layout for the first root: eye, up, d, degenerate flag
    assign sq1_x    = lav_pkg::SQ_IN_W'(l2_reg) << lav_pkg::LEN_SHIFT;
    assign sq1_side = lav_pkg::SIDE_W'({l2_reg == '0,
                                        d3_reg[2], d3_reg[1], d3_reg[0],
                                        up3_reg[2], up3_reg[1], up3_reg[0],
                                        eye3_reg[2], eye3_reg[1], eye3_reg[0]});

    lav_sqrt u_sqrt_len (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p3_valid_reg),
        .in_x      (sq1_x),
        .in_side   (sq1_side),
        .out_valid (sq1_valid),
        .out_root  (lq),
        .out_side  (sq1_out_side)
    );

    lav_div3 u_div_dir (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p4_valid_reg),
        .in_num    (num4_reg),
        .in_neg    (neg4_reg),
        .in_den    (den4_reg),
        .in_side   (side4_reg),
        .out_valid (div1_valid),
        .out_q     (div1_q),
        .out_neg   (div1_neg),
        .out_side  (div1_side)
    );

    // sideband layout for the second root: eye, n, |r|, sign of r, zero flag
    assign sq2_side = {zero11_reg, rneg11_reg,
                       rmag11_reg[2], rmag11_reg[1], rmag11_reg[0],
                       n11_reg[2], n11_reg[1], n11_reg[0],
                       eye11_reg[2], eye11_reg[1], eye11_reg[0]};

    lav_sqrt u_sqrt_orth (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p11_valid_reg),
        .in_x      (vs11_reg),
        .in_side   (sq2_side),
        .out_valid (sq2_valid),
        .out_root  (vq),
        .out_side  (sq2_out_side)
    );

    lav_div3 u_div_up (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p12_valid_reg),
        .in_num    (num12_reg),
        .in_neg    (neg12_reg),
        .in_den    (den12_reg),
        .in_side   (side12_reg),
        .out_valid (div2_valid),
        .out_q     (div2_q),
        .out_neg   (div2_neg),
        .out_side  (div2_side)
    );

    // ---------------- valid chain ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            p5_valid_reg  <= 1'b0;
            p6_valid_reg  <= 1'b0;
            p7_valid_reg  <= 1'b0;
            p8_valid_reg  <= 1'b0;
            p9_valid_reg  <= 1'b0;
            p10_valid_reg <= 1'b0;
            p11_valid_reg <= 1'b0;
            p12_valid_reg <= 1'b0;
            p13_valid_reg <= 1'b0;
            p14_valid_reg <= 1'b0;
            p15_valid_reg <= 1'b0;
            p16_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else if (en) begin
            p1_valid_reg  <= s_axis_tvalid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= sq1_valid;
            p5_valid_reg  <= div1_valid;
            p6_valid_reg  <= p5_valid_reg;
            p7_valid_reg  <= p6_valid_reg;
            p8_valid_reg  <= p7_valid_reg;
            p9_valid_reg  <= p8_valid_reg;
            p10_valid_reg <= p9_valid_reg;
            p11_valid_reg <= p10_valid_reg;
            p12_valid_reg <= sq2_valid;
            p13_valid_reg <= div2_valid;
            p14_valid_reg <= p13_valid_reg;
            p15_valid_reg <= p14_valid_reg;
            p16_valid_reg <= p15_valid_reg;
            m_valid_reg   <= p16_valid_reg;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                // p1: unpack and difference
                eye1_reg[i] <= s_axis_tdata[lav_pkg::IN_W*i +: lav_pkg::IN_W];
                up1_reg[i]  <= s_axis_tdata[lav_pkg::IN_W*(6+i) +: lav_pkg::IN_W];
                d1_reg[i]   <= lav_pkg::D_W'($signed(
                                   s_axis_tdata[lav_pkg::IN_W*(3+i) +: lav_pkg::IN_W]))
                             - lav_pkg::D_W'($signed(
                                   s_axis_tdata[lav_pkg::IN_W*i +: lav_pkg::IN_W]));
                // p2: squares
                eye2_reg[i] <= eye1_reg[i];
                up2_reg[i]  <= up1_reg[i];
                d2_reg[i]   <= d1_reg[i];
                sq2_reg[i]  <= sq_prod[i][lav_pkg::SQ_W-1:0];
                // p3: squared length
                eye3_reg[i] <= eye2_reg[i];
                up3_reg[i]  <= up2_reg[i];
                d3_reg[i]   <= d2_reg[i];
            end
            l2_reg <= l2_next;

            // p4: numerators 2|d|*2^28 + lq over 2*lq
            for (int i = 0; i < 3; i++) begin
                logic signed [lav_pkg::D_W-1:0] dv;
                logic [lav_pkg::D_W-1:0]        dm;
                dv = $signed(sq1_out_side[96 + lav_pkg::D_W*i +: lav_pkg::D_W]);
                dm = dv[lav_pkg::D_W-1] ? lav_pkg::D_W'(-dv) : lav_pkg::D_W'(dv);
                num4_reg[i] <= (lav_pkg::DN_W'(dm) << lav_pkg::N_SHIFT) + lav_pkg::DN_W'(lq);
                neg4_reg[i] <= dv[lav_pkg::D_W-1];
            end
            den4_reg  <= {lq, 1'b0};
            side4_reg <= lav_pkg::SIDE_W'({sq1_out_side[147], sq1_out_side[95:0]});

            // p5: signed unit direction
            for (int i = 0; i < 3; i++) begin
                n5_reg[i]   <= n5_next[i];
                eye5_reg[i] <= div1_side[lav_pkg::IN_W*i +: lav_pkg::IN_W];
                up5_reg[i]  <= div1_side[48 + lav_pkg::IN_W*i +: lav_pkg::IN_W];
            end
            zero5_reg <= div1_side[96];

            // p6: up_i * n_i
            for (int i = 0; i < 3; i++) begin
                pun6_reg[i] <= up5_reg[i] * n5_reg[i];
                n6_reg[i]   <= n5_reg[i];
                up6_reg[i]  <= up5_reg[i];
                eye6_reg[i] <= eye5_reg[i];
            end
            zero6_reg <= zero5_reg;

            // p7: a = up . n
            a7_reg <= (lav_pkg::R_PROD_W+1)'(pun6_reg[0]) + (lav_pkg::R_PROD_W+1)'(pun6_reg[1])
                    + (lav_pkg::R_PROD_W+1)'(pun6_reg[2]);
            for (int i = 0; i < 3; i++) begin
                n7_reg[i]   <= n6_reg[i];
                up7_reg[i]  <= up6_reg[i];
                eye7_reg[i] <= eye6_reg[i];
            end
            zero7_reg <= zero6_reg;

            // p8: a * n_i
            for (int i = 0; i < 3; i++) begin
                an8_reg[i]  <= lav_pkg::PROD_W'(a7_reg) * lav_pkg::PROD_W'(n7_reg[i]);
                n8_reg[i]   <= n7_reg[i];
                up8_reg[i]  <= up7_reg[i];
                eye8_reg[i] <= eye7_reg[i];
            end
            zero8_reg <= zero7_reg;

            // p9: r_i = round((up_i*2^28 - a*n_i) / 2^14)
            for (int i = 0; i < 3; i++) begin
                r9_reg[i]   <= lav_pkg::R_W'(lav_pkg::rnd14(
                                   (lav_pkg::PROD_W'(up8_reg[i]) <<< lav_pkg::UP_SHIFT)
                                   - an8_reg[i]));
                n9_reg[i]   <= n8_reg[i];
                eye9_reg[i] <= eye8_reg[i];
            end
            zero9_reg <= zero8_reg;

            // p10: r_i^2
            for (int i = 0; i < 3; i++) begin
                rmag10_reg[i] <= rm_abs[i][lav_pkg::RMAG_W-1:0];
                rneg10_reg[i] <= r9_reg[i][lav_pkg::R_W-1];
                rsq10_reg[i]  <= lav_pkg::SQ_IN_W'(rm_abs[i][lav_pkg::RMAG_W-1:0])
                               * lav_pkg::SQ_IN_W'(rm_abs[i][lav_pkg::RMAG_W-1:0]);
                n10_reg[i]    <= n9_reg[i];
                eye10_reg[i]  <= eye9_reg[i];
            end
            zero10_reg <= zero9_reg;

            // p11: sum of squares, second degenerate case
            vs11_reg <= rsq10_reg[0] + rsq10_reg[1] + rsq10_reg[2];
            for (int i = 0; i < 3; i++) begin
                rmag11_reg[i] <= rmag10_reg[i];
                n11_reg[i]    <= n10_reg[i];
                eye11_reg[i]  <= eye10_reg[i];
            end
            rneg11_reg <= rneg10_reg;
            zero11_reg <= zero10_reg
                       || ((rsq10_reg[0] + rsq10_reg[1] + rsq10_reg[2]) == '0);

            // p12: numerators 2|r|*2^14 + vq over 2*vq
            for (int i = 0; i < 3; i++) begin
                num12_reg[i] <= (lav_pkg::DN_W'(
                                    sq2_out_side[96 + lav_pkg::RMAG_W*i +: lav_pkg::RMAG_W])
                                 << lav_pkg::V_SHIFT) + lav_pkg::DN_W'(vq);
            end
            neg12_reg  <= sq2_out_side[191:189];
            den12_reg  <= {vq, 1'b0};
            side12_reg <= lav_pkg::SIDE_W'({sq2_out_side[192], sq2_out_side[95:0]});

            // p13: signed v
            for (int i = 0; i < 3; i++) begin
                v13_reg[i]   <= v13_next[i];
                eye13_reg[i] <= div2_side[lav_pkg::IN_W*i +: lav_pkg::IN_W];
                n13_reg[i]   <= div2_side[48 + lav_pkg::IN_W*i +: lav_pkg::IN_W];
            end
            zero13_reg <= div2_side[96];

            // p14: cross-product terms
            cr14_reg[0] <= n13_reg[1] * v13_reg[2];
            cr14_reg[1] <= n13_reg[2] * v13_reg[1];
            cr14_reg[2] <= n13_reg[2] * v13_reg[0];
            cr14_reg[3] <= n13_reg[0] * v13_reg[2];
            cr14_reg[4] <= n13_reg[0] * v13_reg[1];
            cr14_reg[5] <= n13_reg[1] * v13_reg[0];
            for (int i = 0; i < 3; i++) begin
                v14_reg[i]   <= v13_reg[i];
                n14_reg[i]   <= n13_reg[i];
                eye14_reg[i] <= eye13_reg[i];
            end
            zero14_reg <= zero13_reg;

            // p15: w
            for (int i = 0; i < 3; i++) begin
                w15_reg[i]   <= w15_next[i];
                v15_reg[i]   <= v14_reg[i];
                n15_reg[i]   <= n14_reg[i];
                eye15_reg[i] <= eye14_reg[i];
            end
            zero15_reg <= zero14_reg;

            // p16: products with eye
            for (int i = 0; i < 3; i++) begin
                pw16_reg[i] <= w15_reg[i] * eye15_reg[i];
                pv16_reg[i] <= v15_reg[i] * eye15_reg[i];
                pn16_reg[i] <= n15_reg[i] * eye15_reg[i];
                w16_reg[i]  <= w15_reg[i];
                v16_reg[i]  <= v15_reg[i];
                n16_reg[i]  <= n15_reg[i];
            end
            zero16_reg <= zero15_reg;

            // output register: translation sums, zero forcing, packing
            m_data_reg <= m_data_next;
        end
    end

`ifndef SYNTHESIS
    // a zero view row can only come from a degenerate transaction, which zeroes everything
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[111:96] == '0 && m_axis_tdata[127:112] == '0
         && m_axis_tdata[143:128] == '0)
        |-> (m_axis_tdata[95:0] == '0 && m_axis_tdata[215:144] == '0))
        else $error("zero view row with nonzero remaining fields");

    // the view row stays within unit range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ($signed(m_axis_tdata[111:96]) >= -16'sd16384
                        && $signed(m_axis_tdata[111:96]) <= 16'sd16384
                        && $signed(m_axis_tdata[127:112]) >= -16'sd16384
                        && $signed(m_axis_tdata[127:112]) <= 16'sd16384
                        && $signed(m_axis_tdata[143:128]) >= -16'sd16384
                        && $signed(m_axis_tdata[143:128]) <= 16'sd16384))
        else $error("view row component out of unit range");

    // an accepted transaction enters the first stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> p1_valid_reg)
        else $error("accepted transaction lost at pipeline entry");

    // a stall freezes the pipeline occupancy
    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(p1_valid_reg) && $stable(p9_valid_reg) && $stable(p16_valid_reg)))
        else $error("pipeline moved during stall");
`endif

endmodule

// ===== test/tb.sv =====
// tb: self-checking testbench for look_at_view_matrix over its stream ports
// computes untyped expected matrices in its own fixed-point model; checks all twelve fields
// depends on lav_pkg and design/look_at_view_matrix.sv
`timescale 1ns / 1ps

module tb;

    localparam int N_RANDOM    = 780;
    localparam int CALM_ITEMS  = 100;     // last random items run with no idling
    localparam int LATENCY     = 111;
    localparam int CYCLE_LIMIT = 500000;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z (16 bits each)
    logic [lav_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // right_x/y/z, upward_x/y/z, back_x/y/z (16 bits each), shift_row0/1/2 (24 bits each)
    logic [lav_pkg::M_TDATA_W-1:0]   m_axis_tdata;

    logic [lav_pkg::M_TDATA_W-1:0]   pending_matrices[$];
    int                     err_count = 0;
    int                     cycle_count = 0;
    bit                     calm = 1'b0;   // set for the last stretch: no idling on either side
    bit                     rx_started = 1'b0;

    string field_name[12] = '{"right_x", "right_y", "right_z", "upward_x", "upward_y",
                              "upward_z", "back_x", "back_y", "back_z",
                              "shift_row0", "shift_row1", "shift_row2"};

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    look_at_view_matrix u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ---------------------------------------------------------------- fixed-point model

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x   -= res + b;
                res  = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned mag(longint x);
        return (x < 0) ? longint'(-x) : x;
    endfunction

    // half away from zero
    function automatic longint rshift_rnd(longint x, int s);
        longint m;
        m = (mag(x) + (64'd1 << (s - 1))) >> s;
        return (x < 0) ? -m : m;
    endfunction

    function automatic longint div_rnd(longint num, longint unsigned den);
        longint m;
        m = (2 * mag(num) + den) / (2 * den);
        return (num < 0) ? -m : m;
    endfunction

    function automatic longint to_unit(longint x);
        return (x > lav_pkg::ONE_Q14) ? lav_pkg::ONE_Q14 :
               ((x < -lav_pkg::ONE_Q14) ? -lav_pkg::ONE_Q14 : x);
    endfunction

    function automatic logic [lav_pkg::M_TDATA_W-1:0] view_matrix(
            logic [lav_pkg::S_TDATA_W-1:0] item);
        longint eye[3], dir[3], up[3], n[3], r[3], v[3], w[3], t[3];
        longint unsigned len2, vs, lq, vq;
        longint dot_up;
        logic [lav_pkg::M_TDATA_W-1:0] res;
        len2 = 0;
        vs = 0;
        dot_up = 0;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'($signed(item[i*16 +: 16]));
            dir[i] = longint'($signed(item[(3+i)*16 +: 16])) - eye[i];
            up[i]  = longint'($signed(item[(6+i)*16 +: 16]));
            len2  += dir[i] * dir[i];
        end
        // target on the eye point: all-zero matrix
        if (len2 == 0) return res;
        lq = isqrt(len2 << 28);
        for (int i = 0; i < 3; i++) begin
            n[i]    = to_unit(div_rnd(dir[i] * (64'sd1 <<< 28), lq));
            dot_up += up[i] * n[i];
        end
        for (int i = 0; i < 3; i++) begin
            r[i] = rshift_rnd(up[i] * (64'sd1 <<< 28) - dot_up * n[i], 14);
            vs  += r[i] * r[i];
        end
        // up parallel to the view direction: all-zero matrix
        if (vs == 0) return res;
        vq = isqrt(vs);
        for (int i = 0; i < 3; i++) v[i] = to_unit(div_rnd(r[i] * lav_pkg::ONE_Q14, vq));
        w[0] = to_unit(rshift_rnd(n[1] * v[2] - n[2] * v[1], 14));
        w[1] = to_unit(rshift_rnd(n[2] * v[0] - n[0] * v[2], 14));
        w[2] = to_unit(rshift_rnd(n[0] * v[1] - n[1] * v[0], 14));
        t[0] = -rshift_rnd(w[0] * eye[0] + w[1] * eye[1] + w[2] * eye[2], 14);
        t[1] = -rshift_rnd(v[0] * eye[0] + v[1] * eye[1] + v[2] * eye[2], 14);
        t[2] =  rshift_rnd(n[0] * eye[0] + n[1] * eye[1] + n[2] * eye[2], 14);
        for (int i = 0; i < 3; i++) begin
            if (t[i] > lav_pkg::SHIFT_MAX) t[i] = lav_pkg::SHIFT_MAX;
            if (t[i] < lav_pkg::SHIFT_MIN) t[i] = lav_pkg::SHIFT_MIN;
            res[i*16 +: 16]       = w[i][15:0];
            res[(3+i)*16 +: 16]   = v[i][15:0];
            res[(6+i)*16 +: 16]   = 16'(-n[i]);
            res[144 + i*24 +: 24] = t[i][23:0];
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [lav_pkg::S_TDATA_W-1:0] pack_item(int ex, int ey, int ez,
                                                                int tx, int ty, int tz,
                                                                int ux, int uy, int uz);
        return {16'(uz), 16'(uy), 16'(ux), 16'(tz), 16'(ty), 16'(tx),
                16'(ez), 16'(ey), 16'(ex)};
    endfunction

    function automatic int rnd_in(int lo, int hi);
        return int'($urandom_range(hi - lo)) + lo;
    endfunction

    // one camera set-up: well-formed, degenerate, near-degenerate, extreme or full-range noise
    function automatic logic [lav_pkg::S_TDATA_W-1:0] random_item();
        logic [lav_pkg::S_TDATA_W-1:0] item;
        int e[3], t[3], u[3], k;
        for (int i = 0; i < 3; i++) begin
            e[i] = rnd_in(-4096, 4095);
            t[i] = rnd_in(-4096, 4095);
            u[i] = rnd_in(-1024, 1023);
        end
        case ($urandom_range(9))
            0, 1, 2: begin
                for (int i = 0; i < 9; i++) item[i*16 +: 16] = 16'($urandom);
                return item;
            end
            3: t = e;                       // degenerate direction
            4: begin                        // up along the view direction
                k = rnd_in(-3, 3);
                if (k == 0) k = 1;
                for (int i = 0; i < 3; i++) u[i] = k * (t[i] - e[i]);
            end
            5: begin                        // tiny offsets, near-degenerate normalizers
                for (int i = 0; i < 3; i++) begin
                    t[i] = e[i] + rnd_in(-2, 2);
                    u[i] = rnd_in(-2, 2);
                end
            end
            6: begin                        // extreme coordinates
                for (int i = 0; i < 3; i++) begin
                    e[i] = $urandom_range(1) ? 32767 : -32768;
                    t[i] = rnd_in(-32768, 32767);
                    u[i] = rnd_in(-32768, 32767);
                end
            end
            default: ;
        endcase
        return pack_item(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]);
    endfunction

    // ---------------------------------------------------------------- directed table

    typedef struct {
        logic [lav_pkg::S_TDATA_W-1:0] item;
        bit                            typed;     // expected matrix given below, not predicted
        logic [lav_pkg::M_TDATA_W-1:0] matrix;
    } dir_row_t;

    localparam logic [lav_pkg::M_TDATA_W-1:0] ZERO_MATRIX = '0;
    // look down -z with +y up from the origin: identity rotation, zero translation
    localparam logic [lav_pkg::M_TDATA_W-1:0] AXIS_MATRIX =
        {72'd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
         16'sd0, 16'sd0, 16'sd16384};

    dir_row_t dir_table[] = '{
        '{pack_item(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ZERO_MATRIX},
        '{pack_item(100, -200, 300, 100, -200, 300, 0, 256, 0), 1, ZERO_MATRIX},
        '{pack_item(-32768, -32768, -32768, -32768, -32768, -32768,
                    32767, 32767, 32767), 1, ZERO_MATRIX},
        '{pack_item(0, 0, 0, 0, 0, -256, 0, 256, 0), 1, AXIS_MATRIX},
        '{pack_item(0, 0, 0, 256, 0, 0, 512, 0, 0), 1, ZERO_MATRIX},
        '{pack_item(0, 0, 0, 0, 0, -256, 0, 0, 0), 1, ZERO_MATRIX},
        '{pack_item(512, 256, 1024, 0, 0, -256, 0, 256, 0), 0, '0},
        '{pack_item(-32768, -32768, -32768, 32767, 32767, 32767,
                    -32768, 32767, -32768), 0, '0},
        '{pack_item(32767, 32767, 32767, -32768, -32768, -32768,
                    32767, -32768, 0), 0, '0},
        '{pack_item(32767, -32768, 32767, -32768, 32767, -32768,
                    -32768, -32768, -32768), 0, '0},
        '{pack_item(0, 0, 0, 1, 0, 0, 0, 1, 0), 0, '0},
        '{pack_item(0, 0, 0, 1, 1, 1, 1, 0, 0), 0, '0},
        '{pack_item(-1, -1, -1, 0, 0, 0, 0, 0, 1), 0, '0},
        '{pack_item(32767, 32767, 32767, 32767, 32767, -32768, 0, 32767, 0), 0, '0},
        '{pack_item(-32768, 0, 0, 32767, 0, 0, 1, 1, 0), 0, '0},
        '{pack_item(0, 0, 0, 300, 400, 0, -400, 300, 32767), 0, '0},
        '{pack_item(-1, 2, -3, 4, -5, 6, -7, 8, -9), 0, '0},
        '{pack_item(12345, -23456, 4321, -111, 222, -333, 21845, -21846, 10922), 0, '0}
    };

    // ---------------------------------------------------------------- driver

    // one input transaction, with an optional idle burst ahead of it
    task automatic send_item(logic [lav_pkg::S_TDATA_W-1:0] item, bit typed,
                             logic [lav_pkg::M_TDATA_W-1:0] matrix);
        int gap;
        if (!calm && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 17);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_matrices.push_back(typed ? matrix : view_matrix(item));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        rx_started = 1'b1;

        foreach (dir_table[i]) send_item(dir_table[i].item, dir_table[i].typed,
                                         dir_table[i].matrix);

        for (int i = 0; i < N_RANDOM; i++) begin
            // drain the pipe once midway with the sender held off
            if (i == N_RANDOM / 2) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_matrices.size() != 0) @(posedge aclk);
            end
            if (i == N_RANDOM - CALM_ITEMS) calm = 1'b1;
            send_item(random_item(), 0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_matrices.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // ---------------------------------------------------------------- result side

    // ready drops in random bursts until the calm stretch
    initial begin
        wait (rx_started);
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    // check each result transaction against the oldest expected matrix
    always @(posedge aclk) begin
        logic [lav_pkg::M_TDATA_W-1:0] want;
        logic [23:0]          fw, fg;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_matrices.size() == 0) begin
                $error("unexpected result transaction %h", m_axis_tdata);
                err_count++;
            end else begin
                want = pending_matrices.pop_front();
                for (int f = 0; f < 12; f++) begin
                    if (f < 9) begin
                        fw = 24'($signed(want[f*16 +: 16]));
                        fg = 24'($signed(m_axis_tdata[f*16 +: 16]));
                    end else begin
                        fw = want[144 + (f-9)*24 +: 24];
                        fg = m_axis_tdata[144 + (f-9)*24 +: 24];
                    end
                    if (fw !== fg) begin
                        $error("%s: expected %0d, got %0d", field_name[f],
                               $signed(fw), $signed(fg));
                        err_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

// ===== look_at_view_matrix.f =====
design/lav_pkg.sv
design/lav_sqrt.sv
design/lav_div3.sv
design/look_at_view_matrix.sv
test/tb.sv
